/* src/rdq_pkg.sv */
// Shared types and constants for the ring buffer deque.
`default_nettype none
package rdq_pkg;

  localparam int unsigned RDQ_DEPTH = 128;
  localparam int unsigned RDQ_DW    = 32;
  localparam int unsigned RDQ_CNTW  = 7;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_SIZE       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-request command to every cell of one chain
  typedef struct packed {
    logic shift_ins;  // shift toward the tail, new word enters cell 0
    logic shift_del;  // shift toward the head, cell 0 drops out
    logic write_at;   // write new word into the cell at the current count
  } cell_ctl_t;

endpackage
`default_nettype wire

/* src/rdq_cell.sv */
// One storage cell of a deque chain.
`default_nettype none
module rdq_cell #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  wire                          clk,
  input  wire rdq_pkg::cell_ctl_t      ctl,
  input  wire  [CW-1:0]                cnt,
  input  wire  signed [rdq_pkg::RDQ_DW-1:0] word,
  input  wire  signed [rdq_pkg::RDQ_DW-1:0] left_in,
  input  wire  signed [rdq_pkg::RDQ_DW-1:0] right_in,
  output logic signed [rdq_pkg::RDQ_DW-1:0] data_out
);
  import rdq_pkg::*;

  logic signed [RDQ_DW-1:0] data_r;
  logic signed [RDQ_DW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_ins) begin
      data_nxt = left_in;
    end else if (ctl.shift_del) begin
      data_nxt = right_in;
    end else if (ctl.write_at && (cnt == CW'(IDX))) begin
      data_nxt = word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule
`default_nettype wire

/* src/rdq_chain.sv */
// Row of cells holding the deque in order from one end; cell 0 is that end.
`default_nettype none
module rdq_chain #(
  parameter int unsigned NCELL = 127,
  parameter int unsigned CW    = 7
) (
  input  wire                               clk,
  input  wire rdq_pkg::cell_ctl_t           ctl,
  input  wire  [CW-1:0]                     cnt,
  input  wire  signed [rdq_pkg::RDQ_DW-1:0] word,
  output logic signed [rdq_pkg::RDQ_DW-1:0] head_word
);
  import rdq_pkg::*;

  logic signed [RDQ_DW-1:0] cell_q [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic signed [RDQ_DW-1:0] left_w;
    logic signed [RDQ_DW-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = word;
    end else begin : g_mid
      assign left_w = cell_q[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_inner
      assign right_w = cell_q[i+1];
    end

    rdq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cnt      (cnt),
      .word     (word),
      .left_in  (left_w),
      .right_in (right_w),
      .data_out (cell_q[i])
    );
  end

  assign head_word = cell_q[0];

endmodule
`default_nettype wire

/* src/ring_buffer_deque.sv */
// Top level: deque of signed words held in two mirrored cell chains.
// A result is registered on the clock edge that accepts its request.
// One request per cycle unless a held result waits; each push or pop shifts one chain.
// Front chain keeps the front word in cell 0, back chain keeps the back word in cell 0.
// Reset empties the deque (count to zero); stored words are not cleared.
`default_nettype none
module ring_buffer_deque #(
  parameter int unsigned DEPTH = rdq_pkg::RDQ_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] push_value
  input  wire  [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] data_word, [38:32] entry_count, [39] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import rdq_pkg::*;

  localparam int unsigned NCELL = DEPTH - 1;
  localparam int unsigned CW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  logic                     out_valid_r;
  status_t                  status_r;
  status_t                  status_nxt;
  logic signed [RDQ_DW-1:0] data_r;
  logic signed [RDQ_DW-1:0] data_nxt;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            cnt_nxt;

  op_t                      op;
  logic signed [RDQ_DW-1:0] word;
  logic                     acc;
  logic                     empty;
  logic                     full;
  cell_ctl_t                front_ctl;
  cell_ctl_t                back_ctl;
  logic signed [RDQ_DW-1:0] front_word;
  logic signed [RDQ_DW-1:0] back_word;

  assign op        = op_t'(in_tuser);
  assign word      = $signed(in_tdata);
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CW'(NCELL));

  always_comb begin
    front_ctl  = '0;
    back_ctl   = '0;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    data_nxt   = '0;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          front_ctl.shift_ins = acc;
          back_ctl.write_at   = acc;
          cnt_nxt             = cnt_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          back_ctl.shift_ins = acc;
          front_ctl.write_at = acc;
          cnt_nxt            = cnt_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          front_ctl.shift_del = acc;
          data_nxt            = front_word;
          cnt_nxt             = cnt_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          back_ctl.shift_del = acc;
          data_nxt           = back_word;
          cnt_nxt            = cnt_r - 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_nxt = front_word;
        end
      end
      OP_PEEK_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_nxt = back_word;
        end
      end
      OP_SIZE: begin
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  rdq_chain #(
    .NCELL (NCELL),
    .CW    (CW)
  ) u_front (
    .clk       (clk),
    .ctl       (front_ctl),
    .cnt       (cnt_r),
    .word      (word),
    .head_word (front_word)
  );

  rdq_chain #(
    .NCELL (NCELL),
    .CW    (CW)
  ) u_back (
    .clk       (clk),
    .ctl       (back_ctl),
    .cnt       (cnt_r),
    .word      (word),
    .head_word (back_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, RDQ_CNTW'(cnt_r), data_r};

endmodule
`default_nettype wire

/* tb/ring_buffer_deque_tb.sv */
// Self-checking testbench for ring_buffer_deque: directed and random requests vs a scoreboard.
`default_nettype none
module ring_buffer_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdq_pkg::*;

  class deque_scoreboard;
    typedef struct {
      status_t     status;
      logic [31:0] word;
      logic [6:0]  count;
    } deque_result_t;

    deque_result_t result_q[$];
    logic [31:0]   slots[RDQ_DEPTH];
    int unsigned   front_ptr = 0;
    int unsigned   back_ptr = 0;
    int unsigned   errors = 0;
    int unsigned   checked = 0;
    int unsigned   full_hits = 0;
    int unsigned   empty_hits = 0;
    int unsigned   wrap_peeks = 0;
    int unsigned   peak_fill = 0;

    function int unsigned fill_level();
      return (back_ptr + RDQ_DEPTH - front_ptr) % RDQ_DEPTH;
    endfunction

    function void note_request(op_t op, logic [31:0] value);
      deque_result_t r;
      bit is_empty;
      bit is_full;
      is_empty = (front_ptr == back_ptr);
      is_full  = ((back_ptr + 1) % RDQ_DEPTH == front_ptr);
      r.status = ST_OK;
      r.word   = '0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (is_full) begin
            r.status = ST_FULL;
            full_hits++;
          end else if (op == OP_PUSH_FRONT) begin
            front_ptr = (front_ptr + RDQ_DEPTH - 1) % RDQ_DEPTH;
            slots[front_ptr] = value;
          end else begin
            slots[back_ptr] = value;
            back_ptr = (back_ptr + 1) % RDQ_DEPTH;
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (is_empty) begin
            r.status = ST_EMPTY;
            empty_hits++;
          end else begin
            case (op)
              OP_POP_FRONT: begin
                r.word = slots[front_ptr];
                front_ptr = (front_ptr + 1) % RDQ_DEPTH;
              end
              OP_POP_BACK: begin
                back_ptr = (back_ptr + RDQ_DEPTH - 1) % RDQ_DEPTH;
                r.word = slots[back_ptr];
              end
              OP_PEEK_FRONT: r.word = slots[front_ptr];
              default: begin
                if (back_ptr == 0) wrap_peeks++;
                r.word = slots[(back_ptr + RDQ_DEPTH - 1) % RDQ_DEPTH];
              end
            endcase
          end
        end
        OP_CLEAR: begin
          front_ptr = 0;
          back_ptr  = 0;
        end
        default: ;
      endcase
      r.count = 7'(fill_level());
      if (fill_level() > peak_fill) peak_fill = fill_level();
      result_q.insert(result_q.size(), r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(status_t st, logic [39:0] tdata);
      deque_result_t r;
      checked++;
      if (result_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d data=%h", st, tdata));
      end else begin
        r = result_q[0];
        result_q.delete(0);
        if (st !== r.status)
          report($sformatf("result %0d status %0d, wanted %0d", checked, st, r.status));
        if (tdata[31:0] !== r.word)
          report($sformatf("result %0d data %h, wanted %h", checked, tdata[31:0], r.word));
        if (tdata[38:32] !== r.count)
          report($sformatf("result %0d count %0d, wanted %0d", checked, tdata[38:32], r.count));
        if (tdata[39] !== 1'b0)
          report($sformatf("result %0d pad bit is %b", checked, tdata[39]));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [39:0] out_tdata;
  wire  [1:0]  out_tuser;

  deque_scoreboard sb = new();
  bit              calm = 1'b0;
  int unsigned     sent = 0;

  ring_buffer_deque i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_request(op_t op, logic [31:0] value);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = value;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, value);
    sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // 0 fill, 1 drain, 2 mixed
  function automatic op_t pick_op(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 45) return OP_PUSH_FRONT;
        if (r < 90) return OP_PUSH_BACK;
      end
      1: begin
        if (r < 35) return OP_POP_FRONT;
        if (r < 70) return OP_POP_BACK;
        if (r < 80) return OP_PEEK_FRONT;
        if (r < 90) return OP_PEEK_BACK;
      end
      default: begin
        if (r < 3) return OP_CLEAR;
        return op_t'($urandom_range(0, 6));
      end
    endcase
    return op_t'($urandom_range(0, 7));
  endfunction

  initial begin
    int unsigned burst;
    int unsigned mode;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty deque right after reset
    send_request(OP_PEEK_FRONT, 32'h1234_5678);
    send_request(OP_PEEK_BACK, '1);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, 32'h8000_0000);
    send_request(OP_SIZE, 32'h7fff_ffff);
    // push front from empty leaves the back index at zero: peek back wraps
    send_request(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_request(OP_PEEK_BACK, '0);
    send_request(OP_PEEK_FRONT, '0);
    send_request(OP_PUSH_BACK, 32'h8000_0000);
    send_request(OP_PUSH_FRONT, '0);
    send_request(OP_PUSH_BACK, '1);
    send_request(OP_SIZE, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_PEEK_BACK, '0);
    send_request(OP_PEEK_FRONT, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_PUSH_BACK, 32'h5555_5555);
    send_request(OP_PUSH_FRONT, 32'haaaa_aaaa);
    send_request(OP_CLEAR, '1);
    send_request(OP_PEEK_FRONT, '0);
    send_request(OP_SIZE, '0);

    while (sent < 1250) begin
      calm  = ($urandom_range(0, 3) == 0);
      mode  = $urandom_range(0, 2);
      burst = (mode == 0) ? $urandom_range(60, 200) : $urandom_range(20, 120);
      repeat (burst) if (sent < 1250) send_request(pick_op(mode), pick_word());
    end
    calm = 1'b0;

    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.result_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.result_q.size()));

    $display("Ran %0d requests, checked %0d results, peak fill %0d of %0d.",
             sent, sb.checked, sb.peak_fill, RDQ_DEPTH - 1);
    $display("Full pushes %0d, empty reads %0d, wrapped back peeks %0d.",
             sb.full_hits, sb.empty_hits, sb.wrap_peeks);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(status_t'(out_tuser), out_tdata);
  end

endmodule
`default_nettype wire

/* files.f */
src/rdq_pkg.sv
src/rdq_cell.sv
src/rdq_chain.sv
src/ring_buffer_deque.sv
tb/ring_buffer_deque_tb.sv
